>>> sv/rtc3w_pkg.sv
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Shared types, constants and BCD helpers for the three-wire RTC master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

  localparam int unsigned TimeFieldsDef = 7;  // default number of time fields
  localparam int unsigned InFields      = 7;  // time fields carried by an input item

  // Wire protocol constants.
  localparam logic [7:0] WpAddr    = 8'h8E;
  localparam logic [7:0] WpClear   = 8'h00;
  localparam logic [7:0] WpSet     = 8'h80;
  localparam logic [7:0] WriteBase = 8'h80;
  localparam logic [7:0] ReadBase  = 8'h81;

  // Step positions within one transfer.
  localparam logic [5:0] PosFirst    = 6'd1;
  localparam logic [5:0] PosAddrLast = 6'd16;
  localparam logic [5:0] PosDataLast = 6'd32;
  localparam logic [5:0] PosEnd      = 6'd33;
  localparam logic [2:0] BitLast     = 3'd7;

  typedef struct packed {
    logic       start_req;
    logic       opcode;
    logic [6:0] seconds;
    logic [6:0] minutes;
    logic [6:0] hours;
    logic [6:0] day_of_month;
    logic [6:0] month;
    logic [6:0] weekday;
    logic [6:0] year;
    logic       io_in;
  } rtc3w_item_t;

  typedef struct packed {
    logic       pin_rst;
    logic       pin_sclk;
    logic       pin_io_out;
    logic       pin_io_drive;
    logic       busy_res;
    logic       value_valid;
    logic [2:0] value_index;
    logic [7:0] value;
  } rtc3w_res_t;

  // Binary to packed BCD. The tens digit comes from a reciprocal multiply,
  // exact for every 7-bit value; values above 99 give a tens digit above 9.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = {8'b0, v} * 15'd205;
    tens  = prod[14:11];
    units = v - ({tens, 3'b000} + {2'b00, tens, 1'b0});
    return {tens, units[3:0]};
  endfunction

  // Packed BCD to binary: high nibble times ten plus low nibble.
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
  endfunction

endpackage

>>> sv/rtc3w_if.sv
// ----------------------------------------------------------------------------
// rtc3w_in_if / rtc3w_out_if
// Valid/ready channels for tick items and per-tick results.
// ----------------------------------------------------------------------------
interface rtc3w_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic       opcode;
  logic [6:0] seconds;
  logic [6:0] minutes;
  logic [6:0] hours;
  logic [6:0] day_of_month;
  logic [6:0] month;
  logic [6:0] weekday;
  logic [6:0] year;
  logic       io_in;

  modport source (
    output valid, start_req, opcode, seconds, minutes, hours, day_of_month,
           month, weekday, year, io_in,
    input  ready
  );
  modport sink (
    input  valid, start_req, opcode, seconds, minutes, hours, day_of_month,
           month, weekday, year, io_in,
    output ready
  );
endinterface

interface rtc3w_out_if;
  logic       valid;
  logic       ready;
  logic       pin_rst;
  logic       pin_sclk;
  logic       pin_io_out;
  logic       pin_io_drive;
  logic       busy_res;
  logic       value_valid;
  logic [2:0] value_index;
  logic [7:0] value;

  modport source (
    output valid, pin_rst, pin_sclk, pin_io_out, pin_io_drive, busy_res,
           value_valid, value_index, value,
    input  ready
  );
  modport sink (
    input  valid, pin_rst, pin_sclk, pin_io_out, pin_io_drive, busy_res,
           value_valid, value_index, value,
    output ready
  );
endinterface

>>> sv/rtc3w_seq.sv
// ----------------------------------------------------------------------------
// rtc3w_seq
// Transfer sequencer: phase timing, bit shifting and the time field store.
// ----------------------------------------------------------------------------
module rtc3w_seq
  import rtc3w_pkg::*;
#(
  parameter int unsigned TIME_FIELDS = TimeFieldsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  rtc3w_item_t item_i,
  input  logic [7:0]  phase_ticks_i,
  output rtc3w_res_t  res_o
);

  localparam int unsigned IdxW = (TIME_FIELDS > 1) ? $clog2(TIME_FIELDS) : 1;
  localparam logic [3:0] WpSetIdx  = 4'(TIME_FIELDS + 1);
  localparam logic [3:0] ReadCount = 4'(TIME_FIELDS);
  localparam logic [3:0] SetCount  = 4'(TIME_FIELDS + 2);

  logic       active_q, active_d;
  logic       op_q, op_d;
  logic [5:0] pos_q, pos_d;
  logic [3:0] tidx_q, tidx_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] sr_q, sr_d;
  logic [7:0] store_q [TIME_FIELDS];

  // State as seen by this tick, after a possible start.
  logic       act, op, load_store;
  logic [5:0] pos;
  logic [3:0] tidx;
  logic [7:0] cnt, sr;

  logic       last, reading, high, st_we;
  logic [5:0] km;
  logic [2:0] bitno;
  logic [3:0] tm1, count;
  logic [7:0] data_sel;
  logic [6:0] tv [InFields];

  function automatic logic [7:0] xfer_addr(input logic [3:0] t, input logic rd);
    logic [3:0] tm;
    logic [7:0] a;
    tm = t - 4'd1;
    if (rd) begin
      a = ReadBase + {3'b000, t, 1'b0};
    end else if (t == 4'd0 || t == WpSetIdx) begin
      a = WpAddr;
    end else begin
      a = WriteBase + {3'b000, tm, 1'b0};
    end
    return a;
  endfunction

  assign tv[0] = item_i.seconds;
  assign tv[1] = item_i.minutes;
  assign tv[2] = item_i.hours;
  assign tv[3] = item_i.day_of_month;
  assign tv[4] = item_i.month;
  assign tv[5] = item_i.weekday;
  assign tv[6] = item_i.year;

  always_comb begin
    act        = active_q;
    op         = op_q;
    pos        = pos_q;
    tidx       = tidx_q;
    cnt        = cnt_q;
    sr         = sr_q;
    load_store = 1'b0;
    if (!active_q && item_i.start_req) begin
      act        = 1'b1;
      op         = item_i.opcode;
      pos        = '0;
      tidx       = '0;
      cnt        = '0;
      sr         = xfer_addr(4'd0, item_i.opcode);
      load_store = !item_i.opcode;
    end
  end

  // Data byte for the current set transfer.
  always_comb begin
    tm1 = tidx - 4'd1;
    if (tidx == 4'd0) begin
      data_sel = WpClear;
    end else if (tidx >= WpSetIdx) begin
      data_sel = WpSet;
    end else begin
      data_sel = store_q[tm1[IdxW-1:0]];
    end
  end

  always_comb begin
    res_o    = '0;
    active_d = act;
    op_d     = op;
    pos_d    = pos;
    tidx_d   = tidx;
    cnt_d    = cnt;
    sr_d     = sr;
    st_we    = 1'b0;
    km       = pos - 6'd1;
    high     = km[0];
    bitno    = km[3:1];
    reading  = km[4] & op;
    count    = op ? ReadCount : SetCount;
    last     = ({1'b0, cnt} + 9'd1) >= {1'b0, phase_ticks_i};
    if (act) begin
      res_o.busy_res = 1'b1;
      if (pos >= PosFirst && pos <= PosDataLast) begin
        res_o.pin_rst      = 1'b1;
        res_o.pin_sclk     = high;
        res_o.pin_io_drive = !reading;
        res_o.pin_io_out   = !reading & sr[0];
        if (last) begin
          if (reading && !high) begin
            // Sample the line on the last tick of the low phase.
            sr_d = {item_i.io_in, sr[7:1]};
            if (bitno == BitLast) begin
              st_we             = 1'b1;
              res_o.value_valid = 1'b1;
              res_o.value_index = tidx[2:0];
              res_o.value       = from_bcd(sr_d);
            end
          end else if (!reading && high) begin
            if (pos == PosAddrLast) begin
              sr_d = op ? 8'h00 : data_sel;
            end else begin
              sr_d = {1'b0, sr[7:1]};
            end
          end
        end
      end
      if (last) begin
        cnt_d = '0;
        if (pos >= PosEnd) begin
          tidx_d = tidx + 4'd1;
          pos_d  = '0;
          if (tidx_d >= count) begin
            active_d = 1'b0;
          end else begin
            sr_d = xfer_addr(tidx_d, op);
          end
        end else begin
          pos_d = pos + 6'd1;
        end
      end else begin
        cnt_d = cnt + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      op_q     <= 1'b0;
      pos_q    <= '0;
      tidx_q   <= '0;
      cnt_q    <= '0;
      sr_q     <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      op_q     <= op_d;
      pos_q    <= pos_d;
      tidx_q   <= tidx_d;
      cnt_q    <= cnt_d;
      sr_q     <= sr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (load_store) begin
        for (int unsigned i = 0; i < TIME_FIELDS; i++) begin
          store_q[i] <= (i < InFields) ? to_bcd(tv[i % InFields]) : 8'h00;
        end
      end else if (st_we) begin
        store_q[tidx[IdxW-1:0]] <= sr_d;
      end
    end
  end

endmodule

>>> sv/rtc_three_wire_time_transfer_top.sv
// ----------------------------------------------------------------------------
// rtc_three_wire_time_transfer_top
// Three-wire serial master that sets or reads the time of an RTC chip.
// ----------------------------------------------------------------------------
// Each input transaction is one tick of the serial waveform and gives exactly
// one result transaction with the pin levels and status for that tick. A tick
// is taken in every clock cycle that the input is ready: the sequencer
// computes the tick in one pass of logic and the result lands in a single
// output register, so throughput is one tick per clock whenever the result
// side keeps up. The input is ready whenever that output register is empty
// or being taken. phase_ticks sets how many ticks each sclk phase lasts;
// write it only while no sequence is running.
module rtc_three_wire_time_transfer_top
  import rtc3w_pkg::*;
#(
  parameter int unsigned TIME_FIELDS = TimeFieldsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  rtc3w_in_if.sink    in_i,
  rtc3w_out_if.source out_o
);

  logic        accept;
  logic        out_valid_q;
  logic [7:0]  phase_ticks_q;
  rtc3w_item_t item;
  rtc3w_res_t  res_d, res_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign item.start_req    = in_i.start_req;
  assign item.opcode       = in_i.opcode;
  assign item.seconds      = in_i.seconds;
  assign item.minutes      = in_i.minutes;
  assign item.hours        = in_i.hours;
  assign item.day_of_month = in_i.day_of_month;
  assign item.month        = in_i.month;
  assign item.weekday      = in_i.weekday;
  assign item.year         = in_i.year;
  assign item.io_in        = in_i.io_in;

  rtc3w_seq #(
    .TIME_FIELDS(TIME_FIELDS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .item_i       (item),
    .phase_ticks_i(phase_ticks_q),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 8'd1;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        phase_ticks_q <= cfg_data_i;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pin_rst      = res_q.pin_rst;
  assign out_o.pin_sclk     = res_q.pin_sclk;
  assign out_o.pin_io_out   = res_q.pin_io_out;
  assign out_o.pin_io_drive = res_q.pin_io_drive;
  assign out_o.busy_res     = res_q.busy_res;
  assign out_o.value_valid  = res_q.value_valid;
  assign out_o.value_index  = res_q.value_index;
  assign out_o.value        = res_q.value;

endmodule

>>> sv/rtc3w_checker.sv
// ----------------------------------------------------------------------------
// rtc3w_checker
// Port-level checks on the result channel of the three-wire RTC master.
// ----------------------------------------------------------------------------
module rtc3w_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       pin_rst_i,
  input logic       pin_sclk_i,
  input logic       pin_io_out_i,
  input logic       pin_io_drive_i,
  input logic       busy_res_i,
  input logic       value_valid_i,
  input logic [7:0] value_i
);

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result transaction dropped before it was taken");

  // With no sequence running every pin and status field is low.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |->
      !pin_rst_i && !pin_sclk_i && !pin_io_drive_i && !value_valid_i)
    else $error("pin activity reported while idle");

  // A completed read byte is sampled in a low phase with the line released.
  a_read_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && value_valid_i |->
      pin_rst_i && !pin_sclk_i && !pin_io_drive_i && busy_res_i)
    else $error("read byte completed outside a released low phase");

  // A released line shows a low level and a decoded value of at most 165.
  a_released_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pin_io_drive_i |-> !pin_io_out_i && value_i <= 8'd165)
    else $error("released line shows a driven level or decoded value too large");

endmodule

bind rtc_three_wire_time_transfer_top rtc3w_checker u_rtc3w_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pin_rst_i     (out_o.pin_rst),
  .pin_sclk_i    (out_o.pin_sclk),
  .pin_io_out_i  (out_o.pin_io_out),
  .pin_io_drive_i(out_o.pin_io_drive),
  .busy_res_i    (out_o.busy_res),
  .value_valid_i (out_o.value_valid),
  .value_i       (out_o.value)
);

>>> tb/tb_rtc_three_wire_time_transfer_top.sv
// ----------------------------------------------------------------------------
// tb_rtc_three_wire_time_transfer_top
// Self-checking bench for the three-wire RTC master.
// ----------------------------------------------------------------------------
// A local copy of the sequencer advances once per accepted tick transaction
// and queues the pin levels and status it expects for that tick. Each result
// transaction is checked field by field against the oldest queued entry. A
// simple slave answers read-time sequences with chosen bytes on io_in. The
// run covers set and read sequences at several phase lengths, zero among
// them, with random idling on the tick side and random stalls on the result
// side.
// ----------------------------------------------------------------------------
module tb_rtc_three_wire_time_transfer_top;
  import rtc3w_pkg::*;

  localparam int unsigned NF          = TimeFieldsDef;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned RANDOM_TICKS = 200;
  localparam int unsigned MAX_REPORTS = 40;

  localparam logic OpSetTime  = 1'b0;
  localparam logic OpReadTime = 1'b1;

  typedef enum logic [2:0] {
    SlaveZero, SlaveOnes, SlaveBcd, SlaveByte, SlaveNoise
  } slave_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;

  rtc3w_in_if  in_ch ();
  rtc3w_out_if out_ch ();

  rtc_three_wire_time_transfer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the sequencer state and its phase length register.
  logic [7:0] phase_len;
  logic [7:0] tick_cnt;
  logic [5:0] step_pos;
  logic [3:0] xfer_idx;
  logic [7:0] shreg;
  logic       seq_read;
  logic       seq_busy;
  logic [7:0] bcd_regs [NF];

  // Bytes the simulated slave returns, one per read transfer.
  logic [7:0] slave_bytes [NF];

  rtc3w_res_t  pending_pin_states [$];
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned sets_begun;
  int unsigned reads_begun;
  int unsigned fields_read;
  int unsigned cycles;
  bit          idle_on;
  bit          stall_on;
  int unsigned stall_left;
  rtc3w_res_t  want_res;
  rtc3w_res_t  got_res;

  function automatic logic [7:0] pack_bcd(input logic [6:0] v);
    int unsigned tens;
    int unsigned units;
    tens  = v / 10;
    units = v % 10;
    return {4'(tens), 4'(units)};
  endfunction

  function automatic logic [7:0] unpack_bcd(input logic [7:0] b);
    return 8'(b[7:4] * 10 + b[3:0]);
  endfunction

  function automatic logic [7:0] wire_address(input logic [3:0] t);
    if (seq_read == OpReadTime) return ReadBase + {t, 1'b0};
    if (t == 0 || t == NF + 1) return WpAddr;
    return WriteBase + {t - 4'd1, 1'b0};
  endfunction

  function automatic logic [7:0] wire_data(input logic [3:0] t);
    if (t == 0) return WpClear;
    if (t >= NF + 1) return WpSet;
    return bcd_regs[(t - 1) % NF];
  endfunction

  function automatic void reset_sequencer();
    phase_len = 8'd1;
    tick_cnt  = '0;
    step_pos  = '0;
    xfer_idx  = '0;
    shreg     = '0;
    seq_read  = OpSetTime;
    seq_busy  = 1'b0;
    foreach (bcd_regs[i]) bcd_regs[i] = '0;
  endfunction

  // Advances the local sequencer by one tick and returns the pin levels
  // and status that tick should produce.
  task automatic advance_sequencer(input rtc3w_item_t it, output rtc3w_res_t r);
    logic       last;
    logic       high;
    logic       reading;
    logic [4:0] k;
    logic [2:0] bitno;
    r = '0;
    if (!seq_busy) begin
      if (!it.start_req) return;
      seq_busy = 1'b1;
      seq_read = it.opcode;
      step_pos = '0;
      xfer_idx = '0;
      tick_cnt = '0;
      if (seq_read == OpSetTime) begin
        sets_begun++;
        bcd_regs[0] = pack_bcd(it.seconds);
        bcd_regs[1] = pack_bcd(it.minutes);
        bcd_regs[2] = pack_bcd(it.hours);
        bcd_regs[3] = pack_bcd(it.day_of_month);
        bcd_regs[4] = pack_bcd(it.month);
        bcd_regs[5] = pack_bcd(it.weekday);
        bcd_regs[6] = pack_bcd(it.year);
      end else begin
        reads_begun++;
      end
      shreg = wire_address(4'd0);
    end

    // A phase length of zero behaves like one.
    last = ({1'b0, tick_cnt} + 9'd1) >= {1'b0, phase_len};
    r.busy_res = 1'b1;

    if (step_pos >= PosFirst && step_pos <= PosDataLast) begin
      k       = 5'(step_pos - PosFirst);
      high    = k[0];
      bitno   = k[3:1];
      reading = k[4] && (seq_read == OpReadTime);
      r.pin_rst  = 1'b1;
      r.pin_sclk = high;
      if (!reading) begin
        r.pin_io_drive = 1'b1;
        r.pin_io_out   = shreg[0];
      end
      if (last) begin
        if (reading && !high) begin
          // The slave's bit is taken on the last tick before sclk rises.
          shreg = {it.io_in, shreg[7:1]};
          if (bitno == BitLast) begin
            bcd_regs[xfer_idx % NF] = shreg;
            r.value_valid = 1'b1;
            r.value_index = xfer_idx[2:0];
            r.value       = unpack_bcd(shreg);
            fields_read++;
          end
        end else if (!reading && high) begin
          if (step_pos == PosAddrLast)
            shreg = (seq_read == OpReadTime) ? 8'h00 : wire_data(xfer_idx);
          else
            shreg = shreg >> 1;
        end
      end
    end

    if (last) begin
      tick_cnt = '0;
      if (step_pos >= PosEnd) begin
        xfer_idx = xfer_idx + 4'd1;
        step_pos = '0;
        if (xfer_idx >= ((seq_read == OpReadTime) ? NF : NF + 2))
          seq_busy = 1'b0;
        else
          shreg = wire_address(xfer_idx);
      end else begin
        step_pos = step_pos + 6'd1;
      end
    end else begin
      tick_cnt = tick_cnt + 8'd1;
    end
  endtask

  // Level the slave puts on io_in for the tick about to be sent.
  function automatic logic slave_bit();
    logic [5:0] k;
    if (step_pos <= PosAddrLast || step_pos > PosDataLast) return 1'b0;
    k = step_pos - (PosAddrLast + 6'd1);
    return slave_bytes[xfer_idx % NF][k[3:1]];
  endfunction

  function automatic rtc3w_item_t rand_item();
    logic [63:0] raw;
    rtc3w_item_t t;
    raw = {$urandom, $urandom};
    t   = raw[$bits(rtc3w_item_t)-1:0];
    return t;
  endfunction

  function automatic rtc3w_item_t time_item(input logic op,
                                            input logic [6:0] s, m, h, d, mo, w, y);
    rtc3w_item_t t;
    t              = rand_item();
    t.start_req    = 1'b1;
    t.opcode       = op;
    t.seconds      = s;
    t.minutes      = m;
    t.hours        = h;
    t.day_of_month = d;
    t.month        = mo;
    t.weekday      = w;
    t.year         = y;
    return t;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Sends one tick transaction and records what it should produce.
  task automatic send_tick(input rtc3w_item_t it);
    rtc3w_res_t r;
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.start_req    <= it.start_req;
    in_ch.opcode       <= it.opcode;
    in_ch.seconds      <= it.seconds;
    in_ch.minutes      <= it.minutes;
    in_ch.hours        <= it.hours;
    in_ch.day_of_month <= it.day_of_month;
    in_ch.month        <= it.month;
    in_ch.weekday      <= it.weekday;
    in_ch.year         <= it.year;
    in_ch.io_in        <= it.io_in;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    ticks_sent++;
    advance_sequencer(it, r);
    pending_pin_states.push_back(r);
  endtask

  task automatic send_idle(input int unsigned n);
    rtc3w_item_t t;
    repeat (n) begin
      t = rand_item();
      t.start_req = 1'b0;
      send_tick(t);
    end
  endtask

  // Starts a sequence with the given tick and runs it to its end. Ticks
  // sent while busy carry random start requests, which must be ignored.
  task automatic run_sequence(input rtc3w_item_t first, input slave_mode_e mode);
    rtc3w_item_t t;
    foreach (slave_bytes[i]) begin
      case (mode)
        SlaveZero: slave_bytes[i] = 8'h00;
        SlaveOnes: slave_bytes[i] = 8'hFF;
        SlaveBcd:  slave_bytes[i] = pack_bcd(7'($urandom_range(0, 99)));
        default:   slave_bytes[i] = 8'($urandom);
      endcase
    end
    send_tick(first);
    while (seq_busy) begin
      t = rand_item();
      t.start_req = ($urandom_range(0, 3) == 0);
      if (mode != SlaveNoise) t.io_in = slave_bit();
      send_tick(t);
    end
  endtask

  // Lets every outstanding result arrive with the tick side quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pin_states.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_phase_len(input logic [7:0] v);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    phase_len   = v;
  endtask

  task automatic test_set_time_extremes();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    write_phase_len(8'd1);
    send_idle(4);
    run_sequence(time_item(OpSetTime, 0, 99, 127, 59, 23, 7, 100), SlaveNoise);
  endtask

  task automatic test_read_time_patterns();
    send_idle(3);
    // All ones gives nibbles of fifteen, the largest decoded value.
    run_sequence(time_item(OpReadTime, 127, 127, 127, 127, 127, 127, 127), SlaveOnes);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned pick;
    rtc3w_item_t t;
    stop_at = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < stop_at) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      write_phase_len(($urandom_range(0, 3) == 0) ? 8'd2 : 8'd1);
      send_idle($urandom_range(0, 5));
      t = rand_item();
      t.start_req = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick == 0 || t.opcode == OpSetTime) run_sequence(t, SlaveNoise);
      else if (pick < 6) run_sequence(t, SlaveBcd);
      else run_sequence(t, SlaveByte);
    end
  endtask

  // Zero-length phases, with no idling on either side.
  task automatic test_zero_phase_len();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    write_phase_len(8'd0);
    send_idle(2);
    run_sequence(time_item(OpReadTime, 0, 0, 0, 0, 0, 0, 0), SlaveBcd);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_res.pin_rst      = out_ch.pin_rst;
      got_res.pin_sclk     = out_ch.pin_sclk;
      got_res.pin_io_out   = out_ch.pin_io_out;
      got_res.pin_io_drive = out_ch.pin_io_drive;
      got_res.busy_res     = out_ch.busy_res;
      got_res.value_valid  = out_ch.value_valid;
      got_res.value_index  = out_ch.value_index;
      got_res.value        = out_ch.value;
      results_seen++;
      if (pending_pin_states.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no tick pending, expected none, actual %h",
                   $time, got_res);
      end else begin
        want_res = pending_pin_states.pop_front();
        check_field("pin_rst", want_res.pin_rst, got_res.pin_rst);
        check_field("pin_sclk", want_res.pin_sclk, got_res.pin_sclk);
        check_field("pin_io_out", want_res.pin_io_out, got_res.pin_io_out);
        check_field("pin_io_drive", want_res.pin_io_drive, got_res.pin_io_drive);
        check_field("busy_res", want_res.busy_res, got_res.busy_res);
        check_field("value_valid", want_res.value_valid, got_res.value_valid);
        check_field("value_index", want_res.value_index, got_res.value_index);
        check_field("value", want_res.value, got_res.value);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results pending", $time, pending_pin_states.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.start_req    = 1'b0;
    in_ch.opcode       = 1'b0;
    in_ch.seconds      = '0;
    in_ch.minutes      = '0;
    in_ch.hours        = '0;
    in_ch.day_of_month = '0;
    in_ch.month        = '0;
    in_ch.weekday      = '0;
    in_ch.year         = '0;
    in_ch.io_in        = 1'b0;
    out_ch.ready       = 1'b0;
    stall_left         = 0;
    idle_on            = 1'b0;
    stall_on           = 1'b0;
    reset_sequencer();
    foreach (slave_bytes[i]) slave_bytes[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_set_time_extremes();
    test_read_time_patterns();
    test_random_traffic();
    test_zero_phase_len();
    settle();

    $display("Checked %0d tick results over %0d set and %0d read sequences.",
             results_seen, sets_begun, reads_begun);
    $display("Phase lengths 0 and 1 were used, 2 where random traffic picked it; %0d %s",
             fields_read, "time fields were read back.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
